// ===== src/bpf_pkg.sv =====
// Shared types, constants and byte classifiers for the bracketed packet framer.
// No dependencies.
package bpf_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_COUNT_W     = 32;
  localparam int NUM_NAMES       = 7;

  localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'
  localparam logic [7:0] CH_E     = 8'h65; // 'e'
  localparam logic [7:0] CH_N     = 8'h6E; // 'n'
  localparam logic [7:0] CH_D     = 8'h64; // 'd'

  typedef enum logic [3:0] {
    ST_SKIP  = 4'd0,
    ST_OPEN  = 4'd1,
    ST_TYPE  = 4'd2,
    ST_TGAP  = 4'd3,
    ST_ARGS  = 4'd4,
    ST_BODY0 = 4'd5,
    ST_BODY  = 4'd6,
    ST_E1    = 4'd7,
    ST_E2    = 4'd8,
    ST_E3    = 4'd9,
    ST_E4    = 4'd10
  } state_t;

  typedef enum logic [2:0] {
    ROLE_OUT  = 3'd0,
    ROLE_TYPE = 3'd1,
    ROLE_HDR  = 3'd2,
    ROLE_ARG  = 3'd3,
    ROLE_BODY = 3'd4,
    ROLE_END  = 3'd5
  } role_t;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

  typedef struct packed {
    logic restart;
    logic letter;
  } nm_ctl_t;

  localparam logic [7:0] KNOWN_NAME [NUM_NAMES][8] = '{
    '{"r", "d", "a", "t", "a", 8'h00, 8'h00, 8'h00},
    '{"f", "d", "a", "t", "a", 8'h00, 8'h00, 8'h00},
    '{"f", "d", "e", "l", "t", "a", 8'h00, 8'h00},
    '{"r", "c", "e", "r", "t", 8'h00, 8'h00, 8'h00},
    '{"p", "u", "b", "k", "e", "y", 8'h00, 8'h00},
    '{"k", "e", "y", "p", "a", "i", "r", 8'h00},
    '{"p", "r", "i", "v", "k", "e", "y", 8'h00}
  };

  localparam logic [3:0] KNOWN_LEN [NUM_NAMES] = '{
    4'd5, 4'd5, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== src/bracketed_packet_framer_unit.sv =====
// Bracketed packet framer top level: input register, framer, counter, result register.
// Depends on bpf_pkg, bpf_name_match and bpf_fsm.
//
// Usage:
//   Input channel in_valid/in_stall/in_byte carries one text byte per transaction.
//   Result channel out_valid/out_stall carries exactly one result per input byte:
//   out_byte_role, out_frame_done, out_frame_type, out_frame_abort, out_known_count.
//   Packets have the form '[type args]body[end]'; the type name is matched against
//   seven known names one letter at a time, and completed known packets are counted
//   in a COUNT_WIDTH-bit saturating counter (low 32 bits shown).
// Path: a byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless stalled; the framer state is a single register
//   updated by one level of decode logic, so consecutive bytes follow with no gap.
// Stall: out_stall holds the result register; the input register still takes one
//   more byte, after which in_stall is raised until the result is taken.
// Reset: synchronous, active low; framer returns to skipping, the name matcher
//   to all names possible, the counter to zero, and both channels empty.
module bracketed_packet_framer_unit #(
  parameter int COUNT_WIDTH = bpf_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_byte_role,
  output logic       out_frame_done,
  output logic [2:0] out_frame_type,
  output logic       out_frame_abort,
  output logic [31:0] out_known_count
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   step;
  logic                   in_take;

  logic                   out_valid_r;
  logic [2:0]             role_r;
  logic                   done_r;
  logic [2:0]             type_r;
  logic                   abort_r;
  logic [31:0]            known_r;

  bpf_pkg::role_t         role;
  logic                   done;
  logic                   abort_flag;
  bpf_pkg::nm_ctl_t       nm_ctl;
  logic [2:0]             match_type;
  logic [2:0]             frame_type;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [31:0]            count_out;

  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_byte;
  end

  bpf_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data       (in_byte_r),
    .role       (role),
    .done       (done),
    .abort_flag (abort_flag),
    .nm_ctl     (nm_ctl)
  );

  bpf_name_match u_name_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .ctl        (nm_ctl),
    .data       (in_byte_r),
    .match_type (match_type)
  );

  assign frame_type = done ? match_type : bpf_pkg::TYPE_UNKNOWN;

  always_comb begin
    count_nxt = count_r;
    if (done && frame_type != bpf_pkg::TYPE_UNKNOWN && count_r != '1)
      count_nxt = count_r + COUNT_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (step) count_r <= count_nxt;
  end

  generate
    if (COUNT_WIDTH >= bpf_pkg::OUT_COUNT_W) begin : g_cnt_trunc
      assign count_out = count_nxt[31:0];
    end else begin : g_cnt_ext
      assign count_out = {{(bpf_pkg::OUT_COUNT_W - COUNT_WIDTH){1'b0}}, count_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      role_r  <= role;
      done_r  <= done;
      type_r  <= frame_type;
      abort_r <= abort_flag;
      known_r <= count_out;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_role   = role_r;
  assign out_frame_done  = done_r;
  assign out_frame_type  = type_r;
  assign out_frame_abort = abort_r;
  assign out_known_count = known_r;

  a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> role_r == bpf_pkg::ROLE_END)
    else $error("frame_done without end-marker role");

  a_abort_is_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && abort_r |-> role_r == bpf_pkg::ROLE_OUT && !done_r)
    else $error("abort with non-outside role or done");

  a_type_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> type_r == bpf_pkg::TYPE_UNKNOWN)
    else $error("frame_type set without frame_done");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && !step)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== src/bpf_name_match.sv =====
// Incremental type-name matcher: match mask and letter position registers.
// Depends on bpf_pkg.
module bpf_name_match (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  bpf_pkg::nm_ctl_t ctl,
  input  logic [7:0]       data,
  output logic [2:0]       match_type
);

  logic [bpf_pkg::NUM_NAMES-1:0] mask_r, mask_nxt, keep;
  logic [3:0]                    pos_r, pos_nxt;

  always_comb begin
    for (int i = 0; i < bpf_pkg::NUM_NAMES; i++) begin
      keep[i] = (pos_r < bpf_pkg::KNOWN_LEN[i]) &&
                (bpf_pkg::KNOWN_NAME[i][pos_r[2:0]] == data);
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    pos_nxt  = pos_r;
    if (ctl.restart) begin
      mask_nxt = '1;
      pos_nxt  = 4'd0;
    end else if (ctl.letter) begin
      mask_nxt = mask_r & keep;
      if (pos_r != 4'hF) pos_nxt = pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
      pos_r  <= 4'd0;
    end else if (step) begin
      mask_r <= mask_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // first matching name wins
  always_comb begin
    match_type = bpf_pkg::TYPE_UNKNOWN;
    for (int i = bpf_pkg::NUM_NAMES - 1; i >= 0; i--) begin
      if (mask_r[i] && pos_r == bpf_pkg::KNOWN_LEN[i]) match_type = 3'(i + 1);
    end
  end

endmodule

// ===== src/bpf_fsm.sv =====
// Eleven-state packet framer: state register, byte role and abort decode.
// Depends on bpf_pkg.
module bpf_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data,
  output bpf_pkg::role_t    role,
  output logic              done,
  output logic              abort_flag,
  output bpf_pkg::nm_ctl_t  nm_ctl
);

  bpf_pkg::state_t state_r, state_nxt;
  logic            letter, ws, is_open, is_close;

  assign letter   = bpf_pkg::is_letter(data);
  assign ws       = bpf_pkg::is_ws(data);
  assign is_open  = (data == bpf_pkg::CH_OPEN);
  assign is_close = (data == bpf_pkg::CH_CLOSE);

  always_comb begin
    state_nxt = bpf_pkg::ST_SKIP;
    case (state_r)
      bpf_pkg::ST_OPEN: begin
        if (letter) state_nxt = bpf_pkg::ST_TYPE;
      end
      bpf_pkg::ST_TYPE: begin
        if (letter) state_nxt = bpf_pkg::ST_TYPE;
        else if (ws) state_nxt = bpf_pkg::ST_TGAP;
      end
      bpf_pkg::ST_TGAP: begin
        if (ws) state_nxt = bpf_pkg::ST_TGAP;
        else if (!is_close) state_nxt = bpf_pkg::ST_ARGS;
      end
      bpf_pkg::ST_ARGS: begin
        state_nxt = is_close ? bpf_pkg::ST_BODY0 : bpf_pkg::ST_ARGS;
      end
      bpf_pkg::ST_BODY0: begin
        if (!is_open && !is_close) state_nxt = bpf_pkg::ST_BODY;
      end
      bpf_pkg::ST_BODY: begin
        if (is_open) state_nxt = bpf_pkg::ST_E1;
        else if (!is_close) state_nxt = bpf_pkg::ST_BODY;
      end
      bpf_pkg::ST_E1: begin
        if (data == bpf_pkg::CH_E) state_nxt = bpf_pkg::ST_E2;
      end
      bpf_pkg::ST_E2: begin
        if (data == bpf_pkg::CH_N) state_nxt = bpf_pkg::ST_E3;
      end
      bpf_pkg::ST_E3: begin
        if (data == bpf_pkg::CH_D) state_nxt = bpf_pkg::ST_E4;
      end
      bpf_pkg::ST_E4: begin
        state_nxt = bpf_pkg::ST_SKIP;
      end
      default: begin
        if (is_open) state_nxt = bpf_pkg::ST_OPEN;
      end
    endcase
  end

  always_comb begin
    role           = bpf_pkg::ROLE_OUT;
    done           = 1'b0;
    abort_flag     = 1'b0;
    nm_ctl.restart = 1'b0;
    nm_ctl.letter  = 1'b0;
    case (state_r)
      bpf_pkg::ST_OPEN: begin
        if (letter) begin
          role          = bpf_pkg::ROLE_TYPE;
          nm_ctl.letter = 1'b1;
        end else abort_flag = 1'b1;
      end
      bpf_pkg::ST_TYPE: begin
        if (letter) begin
          role          = bpf_pkg::ROLE_TYPE;
          nm_ctl.letter = 1'b1;
        end else if (ws) role = bpf_pkg::ROLE_HDR;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_TGAP: begin
        if (ws) role = bpf_pkg::ROLE_HDR;
        else if (!is_close) role = bpf_pkg::ROLE_ARG;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_ARGS: begin
        role = is_close ? bpf_pkg::ROLE_HDR : bpf_pkg::ROLE_ARG;
      end
      bpf_pkg::ST_BODY0: begin
        if (!is_open && !is_close) role = bpf_pkg::ROLE_BODY;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_BODY: begin
        if (is_open) role = bpf_pkg::ROLE_END;
        else if (is_close) abort_flag = 1'b1;
        else role = bpf_pkg::ROLE_BODY;
      end
      bpf_pkg::ST_E1: begin
        if (data == bpf_pkg::CH_E) role = bpf_pkg::ROLE_END;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_E2: begin
        if (data == bpf_pkg::CH_N) role = bpf_pkg::ROLE_END;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_E3: begin
        if (data == bpf_pkg::CH_D) role = bpf_pkg::ROLE_END;
        else abort_flag = 1'b1;
      end
      bpf_pkg::ST_E4: begin
        if (is_close) begin
          role = bpf_pkg::ROLE_END;
          done = 1'b1;
        end else abort_flag = 1'b1;
      end
      default: begin
        if (is_open) begin
          role           = bpf_pkg::ROLE_HDR;
          nm_ctl.restart = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bpf_pkg::ST_SKIP;
    else if (step) state_r <= state_nxt;
  end

endmodule
